// ----- hw/rtl/fdc_pkg.sv -----
// Shared types, constants and the type-letter decode for the format descriptor compiler.
// No dependencies; the other files that use this package refer to it by scoped names.
package fdc_pkg;

    localparam int CODE_DEPTH_DEF = 32;

    localparam int CHAR_W = 8;
    localparam int CODE_W = 17;
    localparam int REP_W  = 15;
    localparam int RPT_W  = 14;
    localparam int NEST_W = 7;
    localparam int TYPE_W = 3;

    localparam logic [REP_W-1:0]  AFTER_ITEM = 15'h7FFF;
    localparam logic [CODE_W-1:0] REPEAT_MAX = 17'd9999;

    localparam logic signed [NEST_W-1:0] NEST_MAX = 7'sd63;
    localparam logic signed [NEST_W-1:0] NEST_MIN = -7'sd64;

    localparam logic [CODE_W-1:0] CODE_ERROR = 17'd9;
    localparam logic [CODE_W-1:0] CODE_EMPTY = 17'd0;

    localparam logic [TYPE_W-1:0] SPEC_NONE = 3'd0;
    localparam logic [TYPE_W-1:0] SPEC_B16  = 3'd4;
    localparam logic [TYPE_W-1:0] SPEC_B8   = 3'd5;
    localparam logic [TYPE_W-1:0] SPEC_B32  = 3'd6;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_2     = 8'h32;
    localparam logic [CHAR_W-1:0] CH_3     = 8'h33;
    localparam logic [CHAR_W-1:0] CH_6     = 8'h36;
    localparam logic [CHAR_W-1:0] CH_8     = 8'h38;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic parse;
        logic emit_single;
        logic emit_step;
        logic clear;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic single_answer;
        logic last_step;
    } t_stat;

    function automatic logic [TYPE_W-1:0] type_of(input logic [CHAR_W-1:0] c);
        logic [TYPE_W-1:0] t;
        case (c)
            8'h46, 8'h66: t = 3'd1;
            8'h49, 8'h69: t = 3'd2;
            8'h41, 8'h61: t = 3'd3;
            8'h4A, 8'h6A: t = 3'd4;
            8'h4B, 8'h6B: t = 3'd5;
            8'h5A, 8'h7A: t = 3'd6;
            8'h43, 8'h63: t = 3'd7;
            default:      t = 3'd0;
        endcase
        return t;
    endfunction

endpackage

// ----- hw/rtl/fdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/fdc_ctrl.sv -----
// Controller state machine: accepts characters, then sequences the answer.
// Depends on fdc_pkg for the command and status structs.
module fdc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_end_of_string,
    input  fdc_pkg::t_stat i_stat,
    output fdc_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FINAL = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.parse = 1'b1;
                    if (i_end_of_string) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                // The final character has been folded in; decide the answer form.
                if (i_stat.single_answer) begin
                    o_cmd.emit_single = 1'b1;
                    o_cmd.clear       = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_stat.last_step) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- hw/rtl/fdc_datapath.sv -----
// Datapath: parse registers, code store and the registered result ports.
// Depends on fdc_pkg and fdc_ram.
module fdc_datapath #(
    parameter int CODE_DEPTH = fdc_pkg::CODE_DEPTH_DEF,
    parameter int CNT_W      = $clog2(CODE_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [fdc_pkg::CHAR_W-1:0]   i_char_in,
    input  fdc_pkg::t_cmd                i_cmd,
    output fdc_pkg::t_stat               o_stat,
    output logic                         o_valid,
    output logic [fdc_pkg::CODE_W-1:0]   o_code,
    output logic [CNT_W-1:0]             o_code_count,
    output logic                         o_last
);

    localparam int AW = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CODE_DEPTH);

    logic [CNT_W-1:0]                  r_count, n_count;
    logic [fdc_pkg::REP_W-1:0]         r_rep, n_rep;
    logic signed [fdc_pkg::NEST_W-1:0] r_nest, n_nest;
    logic                              r_err, n_err;
    logic [1:0]                        r_pos, n_pos;
    logic [fdc_pkg::CHAR_W-1:0]        r_pfx, n_pfx;
    logic [fdc_pkg::TYPE_W-1:0]        r_spec, n_spec;
    logic [CNT_W-1:0]                  r_idx, n_idx;

    logic                              r_out_valid;
    logic [fdc_pkg::CODE_W-1:0]        r_out_code;
    logic [CNT_W-1:0]                  r_out_count;
    logic                              r_out_last;

    logic                              after;
    logic                              do_store;
    logic [fdc_pkg::CODE_W-1:0]        store_val;
    logic [fdc_pkg::RPT_W-1:0]         base;
    logic [fdc_pkg::RPT_W-1:0]         rep1;
    logic [fdc_pkg::CODE_W-1:0]        rep10;
    logic [fdc_pkg::CODE_W-1:0]        digit_val;
    logic [fdc_pkg::TYPE_W-1:0]        kf;
    logic                              ram_we;
    logic [AW-1:0]                     ram_raddr;
    logic [fdc_pkg::CODE_W-1:0]        ram_q;
    logic                              err_final;
    logic [CNT_W-1:0]                  idx_inc;

    fdc_ram #(
        .WIDTH(fdc_pkg::CODE_W),
        .DEPTH(CODE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(store_val),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    assign after     = (r_rep == fdc_pkg::AFTER_ITEM);
    assign base      = after ? '0 : r_rep[fdc_pkg::RPT_W-1:0];
    assign digit_val = fdc_pkg::CODE_W'(base) * 17'd10
                     + fdc_pkg::CODE_W'(i_char_in - fdc_pkg::CH_0);
    assign rep1      = (after || (r_rep == '0)) ? 14'd1 : r_rep[fdc_pkg::RPT_W-1:0];
    assign rep10     = fdc_pkg::CODE_W'(rep1) * 17'd10;
    assign kf        = fdc_pkg::type_of(i_char_in);
    assign idx_inc   = r_idx + 1'b1;
    assign err_final = r_err || (r_nest != '0);

    // During emission the read runs one entry ahead of the output register.
    assign ram_raddr = i_cmd.emit_step ? idx_inc[AW-1:0] : r_idx[AW-1:0];

    assign o_stat.single_answer = (r_spec != fdc_pkg::SPEC_NONE) || err_final
                                || (r_count == '0);
    assign o_stat.last_step     = (idx_inc == r_count);

    always_comb begin
        n_count   = r_count;
        n_rep     = r_rep;
        n_nest    = r_nest;
        n_err     = r_err;
        n_pos     = r_pos;
        n_pfx     = r_pfx;
        n_spec    = r_spec;
        n_idx     = r_idx;
        do_store  = 1'b0;
        store_val = '0;
        ram_we    = 1'b0;

        if (i_cmd.parse) begin
            // Leading B8, B08, B16 or B32 detection.
            if (r_pos == 2'd0) begin
                n_pfx = (i_char_in == fdc_pkg::CH_UB || i_char_in == fdc_pkg::CH_LB)
                      ? fdc_pkg::CH_UB : fdc_pkg::CH_NONE;
            end else if (r_pos == 2'd1) begin
                if (r_pfx == fdc_pkg::CH_UB) begin
                    if (i_char_in == fdc_pkg::CH_8) begin
                        n_spec = fdc_pkg::SPEC_B8;
                        n_pfx  = fdc_pkg::CH_NONE;
                    end else begin
                        n_pfx = i_char_in;
                    end
                end
            end else if (r_pos == 2'd2 && r_spec == fdc_pkg::SPEC_NONE) begin
                if (r_pfx == fdc_pkg::CH_0 && i_char_in == fdc_pkg::CH_8) begin
                    n_spec = fdc_pkg::SPEC_B8;
                end
                if (r_pfx == fdc_pkg::CH_1 && i_char_in == fdc_pkg::CH_6) begin
                    n_spec = fdc_pkg::SPEC_B16;
                end
                if (r_pfx == fdc_pkg::CH_3 && i_char_in == fdc_pkg::CH_2) begin
                    n_spec = fdc_pkg::SPEC_B32;
                end
            end
            if (r_pos != 2'd3) begin
                n_pos = r_pos + 2'd1;
            end

            if (i_char_in == fdc_pkg::CH_SPACE) begin
                n_rep = r_rep;
            end else if (i_char_in inside {[fdc_pkg::CH_0:fdc_pkg::CH_9]}) begin
                if (after) begin
                    n_err = 1'b1;
                end
                n_rep = (digit_val > fdc_pkg::REPEAT_MAX)
                      ? fdc_pkg::REPEAT_MAX[fdc_pkg::REP_W-1:0]
                      : digit_val[fdc_pkg::REP_W-1:0];
            end else if (i_char_in == fdc_pkg::CH_OPEN) begin
                if (after) begin
                    n_err = 1'b1;
                end
                if (r_nest < fdc_pkg::NEST_MAX) begin
                    n_nest = r_nest + 7'sd1;
                end
                do_store  = 1'b1;
                store_val = rep10;
                n_rep     = '0;
            end else if (i_char_in == fdc_pkg::CH_CLOSE) begin
                if (!after) begin
                    n_err = 1'b1;
                end
                if (r_nest > fdc_pkg::NEST_MIN) begin
                    n_nest = r_nest - 7'sd1;
                end
                do_store  = 1'b1;
                store_val = '0;
                n_rep     = fdc_pkg::AFTER_ITEM;
            end else if (i_char_in == fdc_pkg::CH_COMMA) begin
                if (!after) begin
                    n_err = 1'b1;
                end
                n_rep = '0;
            end else begin
                if (kf != 3'd0) begin
                    if (after) begin
                        n_err = 1'b1;
                    end
                    do_store  = 1'b1;
                    store_val = rep10 + fdc_pkg::CODE_W'(kf);
                end else begin
                    n_err = 1'b1;
                end
                n_rep = fdc_pkg::AFTER_ITEM;
            end

            // A code that does not fit in the store is dropped and flagged.
            if (do_store) begin
                if (r_count < DEPTH_CNT) begin
                    ram_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end else begin
                    n_err = 1'b1;
                end
            end
        end

        if (i_cmd.emit_step) begin
            n_idx = idx_inc;
        end

        if (i_cmd.clear) begin
            n_count = '0;
            n_rep   = '0;
            n_nest  = '0;
            n_err   = 1'b0;
            n_pos   = 2'd0;
            n_pfx   = fdc_pkg::CH_NONE;
            n_spec  = fdc_pkg::SPEC_NONE;
            n_idx   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rep       <= '0;
            r_nest      <= '0;
            r_err       <= 1'b0;
            r_pos       <= 2'd0;
            r_pfx       <= fdc_pkg::CH_NONE;
            r_spec      <= fdc_pkg::SPEC_NONE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rep       <= n_rep;
            r_nest      <= n_nest;
            r_err       <= n_err;
            r_pos       <= n_pos;
            r_pfx       <= n_pfx;
            r_spec      <= n_spec;
            r_idx       <= n_idx;
            r_out_valid <= i_cmd.emit_single || i_cmd.emit_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            if (r_spec != fdc_pkg::SPEC_NONE) begin
                r_out_code  <= fdc_pkg::CODE_W'(r_spec);
                r_out_count <= CNT_W'(1);
            end else if (err_final) begin
                r_out_code  <= fdc_pkg::CODE_ERROR;
                r_out_count <= CNT_W'(1);
            end else begin
                r_out_code  <= fdc_pkg::CODE_EMPTY;
                r_out_count <= '0;
            end
            r_out_last <= 1'b1;
        end else if (i_cmd.emit_step) begin
            r_out_code  <= ram_q;
            r_out_count <= r_count;
            r_out_last  <= o_stat.last_step;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code       = r_out_code;
    assign o_code_count = r_out_count;
    assign o_last       = r_out_last;

endmodule

// ----- hw/rtl/format_descriptor_compiler_unit.sv -----
// Top level of the format descriptor compiler: controller plus datapath.
// Depends on fdc_pkg, fdc_ctrl, fdc_datapath and fdc_ram.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------------------
//  input    | start, busy        | i_char_in, i_end_of_string
//  result   | o_valid (strobe)   | o_code, o_code_count, o_last
//
// One character is taken per cycle while busy is low.
// After the final character, busy stays high for one cycle when the answer is a
// single code (error, B prefix or empty); that code is registered out of the S_FINAL
// state. Otherwise busy stays high through S_FINAL and S_EMIT until the last of the
// N stored codes has left; the codes leave one per cycle from the code store's read
// port, the read of the first being issued in S_FINAL.
// Reset (synchronous, active low) returns all control state to idle; the code
// store needs no clearing. The receiver cannot stall the result strobe.
module format_descriptor_compiler_unit #(
    parameter int CODE_DEPTH = fdc_pkg::CODE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fdc_pkg::CHAR_W-1:0]          i_char_in,
    input  logic                                i_end_of_string,
    output logic                                o_valid,
    output logic [fdc_pkg::CODE_W-1:0]          o_code,
    output logic [$clog2(CODE_DEPTH + 1)-1:0]   o_code_count,
    output logic                                o_last
);

    localparam int CNT_W = $clog2(CODE_DEPTH + 1);

    fdc_pkg::t_cmd  cmd;
    fdc_pkg::t_stat stat;

    fdc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_end_of_string(i_end_of_string),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_busy         (busy)
    );

    fdc_datapath #(
        .CODE_DEPTH(CODE_DEPTH),
        .CNT_W     (CNT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_in   (i_char_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_code      (o_code),
        .o_code_count(o_code_count),
        .o_last      (o_last)
    );

endmodule

// ----- hw/rtl/fdc_checker.sv -----
// Port-level checks on the format descriptor compiler's result transactions.
// Depends on format_descriptor_compiler_unit, to which it is bound below.
module fdc_checker #(
    parameter int CNT_W = 6
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             i_end_of_string,
    input logic             o_valid,
    input logic [16:0]      o_code,
    input logic [CNT_W-1:0] o_code_count,
    input logic             o_last
);

    // An answer is one unbroken burst of transactions.
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("answer burst broken before its last transaction");

    // No new character can be taken while an answer is still going out.
    a_busy_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("block idle in the middle of an answer");

    // A character that does not end the string produces no transaction next.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_end_of_string |=> !o_valid)
        else $error("result appeared right after a non-final character");

    // An empty answer is a single transaction with code zero.
    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_code_count == '0) |-> o_last && (o_code == '0))
        else $error("malformed empty answer");

endmodule

bind format_descriptor_compiler_unit fdc_checker #(.CNT_W(CNT_W)) u_fdc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_end_of_string(i_end_of_string),
    .o_valid        (o_valid),
    .o_code         (o_code),
    .o_code_count   (o_code_count),
    .o_last         (o_last)
);

// ----- tb/sv/tb_format_descriptor_compiler_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for format_descriptor_compiler_unit: format strings go in one
// character per transaction, and every compiled code is checked against a local predictor.
// Depends on fdc_pkg and the compiler unit RTL.
module tb_format_descriptor_compiler_unit;

    localparam int DEPTH         = fdc_pkg::CODE_DEPTH_DEF;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_CHARS  = 40;
    localparam int QUIET_CHARS   = 15;

    localparam logic [fdc_pkg::TYPE_W-1:0] KIND_NONE = 3'd0;
    localparam logic [fdc_pkg::TYPE_W-1:0] KIND_F    = 3'd1;
    localparam logic [fdc_pkg::TYPE_W-1:0] KIND_I    = 3'd2;
    localparam logic [fdc_pkg::TYPE_W-1:0] KIND_A    = 3'd3;
    localparam logic [fdc_pkg::TYPE_W-1:0] KIND_J    = 3'd4;
    localparam logic [fdc_pkg::TYPE_W-1:0] KIND_K    = 3'd5;
    localparam logic [fdc_pkg::TYPE_W-1:0] KIND_Z    = 3'd6;
    localparam logic [fdc_pkg::TYPE_W-1:0] KIND_C    = 3'd7;

    localparam string KIND_CHARS = "FIAJKZC";
    localparam string JUNK_CHARS = " (),09Ff#";

    typedef struct packed {
        logic [fdc_pkg::CODE_W-1:0] code;
        logic [CNT_W-1:0]           count;
        logic                       last;
    } t_answer;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic [fdc_pkg::CHAR_W-1:0]    i_char_in = '0;
    logic                          i_end_of_string = 1'b0;
    logic                          busy;
    logic                          o_valid;
    logic [fdc_pkg::CODE_W-1:0]    o_code;
    logic [CNT_W-1:0]              o_code_count;
    logic                          o_last;

    // Predictor state for the string being compiled.
    logic [fdc_pkg::CODE_W-1:0]    code_mem [DEPTH];
    int                            codes_held;
    logic [fdc_pkg::REP_W-1:0]     repeat_now;
    int                            depth_now;
    logic                          bad_seen;
    logic [1:0]                    pos_seen;
    logic [fdc_pkg::CHAR_W-1:0]    prefix_ch;
    logic [fdc_pkg::TYPE_W-1:0]    spec_code;

    t_answer                       answer_q[$];
    t_answer                       want;
    logic [fdc_pkg::CHAR_W-1:0]    fmt_buf[$];
    int                            gap_pct = 25;
    int                            chars_sent;
    int                            strings_sent;
    int                            codes_checked;
    int                            fail_count;
    int                            cycle_count;

    format_descriptor_compiler_unit #(
        .CODE_DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_char_in      (i_char_in),
        .i_end_of_string(i_end_of_string),
        .o_valid        (o_valid),
        .o_code         (o_code),
        .o_code_count   (o_code_count),
        .o_last         (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Letters match in either case, so fold bit 5 before decoding.
    function automatic logic [fdc_pkg::TYPE_W-1:0] letter_kind(
        input logic [fdc_pkg::CHAR_W-1:0] c
    );
        case (c | 8'h20)
            "f":     return KIND_F;
            "i":     return KIND_I;
            "a":     return KIND_A;
            "j":     return KIND_J;
            "k":     return KIND_K;
            "z":     return KIND_Z;
            "c":     return KIND_C;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic int repeat_or_one();
        return (repeat_now == fdc_pkg::AFTER_ITEM || repeat_now == '0)
             ? 1 : int'(repeat_now);
    endfunction

    task automatic keep_code(input int value);
        if (codes_held < DEPTH) begin
            code_mem[codes_held] = value[fdc_pkg::CODE_W-1:0];
            codes_held++;
        end else begin
            bad_seen = 1'b1;
        end
    endtask

    task automatic clear_compiler();
        codes_held = 0;
        repeat_now = '0;
        depth_now  = 0;
        bad_seen   = 1'b0;
        pos_seen   = '0;
        prefix_ch  = fdc_pkg::CH_NONE;
        spec_code  = fdc_pkg::SPEC_NONE;
    endtask

    task automatic compile_char(input logic [fdc_pkg::CHAR_W-1:0] c, input logic eos);
        logic                       after;
        int                         acc;
        logic [fdc_pkg::TYPE_W-1:0] kind;
        t_answer                    a;
        after = (repeat_now == fdc_pkg::AFTER_ITEM);

        // Leading B8, B08, B16 or B32 selects a fixed answer.
        if (pos_seen == 2'd0) begin
            prefix_ch = (c == fdc_pkg::CH_UB || c == fdc_pkg::CH_LB)
                      ? fdc_pkg::CH_UB : fdc_pkg::CH_NONE;
        end else if (pos_seen == 2'd1) begin
            if (prefix_ch == fdc_pkg::CH_UB) begin
                if (c == fdc_pkg::CH_8) begin
                    spec_code = fdc_pkg::SPEC_B8;
                    prefix_ch = fdc_pkg::CH_NONE;
                end else begin
                    prefix_ch = c;
                end
            end
        end else if (pos_seen == 2'd2 && spec_code == fdc_pkg::SPEC_NONE) begin
            if (prefix_ch == fdc_pkg::CH_0 && c == fdc_pkg::CH_8) spec_code = fdc_pkg::SPEC_B8;
            if (prefix_ch == fdc_pkg::CH_1 && c == fdc_pkg::CH_6) spec_code = fdc_pkg::SPEC_B16;
            if (prefix_ch == fdc_pkg::CH_3 && c == fdc_pkg::CH_2) spec_code = fdc_pkg::SPEC_B32;
        end
        if (pos_seen != 2'd3) pos_seen++;

        if (c == fdc_pkg::CH_SPACE) begin
        end else if (c >= fdc_pkg::CH_0 && c <= fdc_pkg::CH_9) begin
            acc = (after ? 0 : int'(repeat_now)) * 10 + int'(c - fdc_pkg::CH_0);
            if (after) bad_seen = 1'b1;
            repeat_now = (acc > int'(fdc_pkg::REPEAT_MAX))
                       ? fdc_pkg::REPEAT_MAX[fdc_pkg::REP_W-1:0] : acc[fdc_pkg::REP_W-1:0];
        end else if (c == fdc_pkg::CH_OPEN) begin
            if (after) bad_seen = 1'b1;
            if (depth_now < int'(fdc_pkg::NEST_MAX)) depth_now++;
            keep_code(10 * repeat_or_one());
            repeat_now = '0;
        end else if (c == fdc_pkg::CH_CLOSE) begin
            if (!after) bad_seen = 1'b1;
            if (depth_now > int'(fdc_pkg::NEST_MIN)) depth_now--;
            keep_code(0);
            repeat_now = fdc_pkg::AFTER_ITEM;
        end else if (c == fdc_pkg::CH_COMMA) begin
            if (!after) bad_seen = 1'b1;
            repeat_now = '0;
        end else begin
            kind = letter_kind(c);
            if (kind != KIND_NONE) begin
                if (after) bad_seen = 1'b1;
                keep_code(int'(kind) + 10 * repeat_or_one());
            end else begin
                bad_seen = 1'b1;
            end
            repeat_now = fdc_pkg::AFTER_ITEM;
        end

        if (eos) begin
            if (depth_now != 0) bad_seen = 1'b1;
            if (spec_code != fdc_pkg::SPEC_NONE || bad_seen || codes_held == 0) begin
                a.code  = (spec_code != fdc_pkg::SPEC_NONE) ? fdc_pkg::CODE_W'(spec_code)
                        : (bad_seen ? fdc_pkg::CODE_ERROR : fdc_pkg::CODE_EMPTY);
                a.count = (spec_code != fdc_pkg::SPEC_NONE || bad_seen)
                        ? CNT_W'(1) : CNT_W'(0);
                a.last  = 1'b1;
                answer_q.push_back(a);
            end else begin
                for (int i = 0; i < codes_held; i++) begin
                    a.code  = code_mem[i];
                    a.count = CNT_W'(codes_held);
                    a.last  = (i == codes_held - 1);
                    answer_q.push_back(a);
                end
            end
            clear_compiler();
        end
    endtask

    // Outputs are sampled mid-cycle, where they are stable.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid) begin
            codes_checked++;
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result code=%0d count=%0d last=%0b",
                         $time, o_code, o_code_count, o_last);
                fail_count++;
            end else begin
                want = answer_q.pop_front();
                if (o_code !== want.code) begin
                    $display("%0t: code expected %0d actual %0d", $time, want.code, o_code);
                    fail_count++;
                end
                if (o_code_count !== want.count) begin
                    $display("%0t: code_count expected %0d actual %0d",
                             $time, want.count, o_code_count);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // Called at a rising edge; returns at the rising edge that accepted the transaction,
    // or after an idle burst.
    task automatic send_char(input logic [fdc_pkg::CHAR_W-1:0] c, input logic eos);
        start           <= 1'b1;
        i_char_in       <= c;
        i_end_of_string <= eos;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        compile_char(c, eos);
        chars_sent++;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic send_fmt();
        for (int i = 0; i < fmt_buf.size(); i++) begin
            send_char(fmt_buf[i], i == fmt_buf.size() - 1);
        end
        fmt_buf.delete();
        strings_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) fmt_buf.push_back(s[i]);
        send_fmt();
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_space();
        if ($urandom_range(0, 5) == 0) fmt_buf.push_back(fdc_pkg::CH_SPACE);
    endtask

    task automatic add_repeat();
        int n;
        if ($urandom_range(0, 1) == 1) begin
            n = ($urandom_range(0, 7) == 0) ? 5 : $urandom_range(1, 2);
            repeat (n) begin
                fmt_buf.push_back(fdc_pkg::CHAR_W'(fdc_pkg::CH_0 + $urandom_range(0, 9)));
            end
        end
    endtask

    task automatic add_list(input int level);
        int                         items;
        logic [fdc_pkg::CHAR_W-1:0] c;
        items = $urandom_range(1, 4 - level);
        for (int i = 0; i < items; i++) begin
            if (i != 0) begin
                add_space();
                fmt_buf.push_back(fdc_pkg::CH_COMMA);
                add_space();
            end
            add_repeat();
            if (level < 2 && $urandom_range(0, 3) == 0) begin
                fmt_buf.push_back(fdc_pkg::CH_OPEN);
                add_list(level + 1);
                fmt_buf.push_back(fdc_pkg::CH_CLOSE);
            end else begin
                c = KIND_CHARS[$urandom_range(0, 6)];
                if ($urandom_range(0, 1) == 1) c = c | 8'h20;
                fmt_buf.push_back(c);
            end
        end
    endtask

    task automatic add_noise(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) begin
            fmt_buf.push_back(fdc_pkg::CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_random_fmt();
        int idx;
        case ($urandom_range(0, 9))
            6: begin
                fmt_buf.push_back($urandom_range(0, 1) ? fdc_pkg::CH_UB : fdc_pkg::CH_LB);
                case ($urandom_range(0, 4))
                    0: fmt_buf.push_back(fdc_pkg::CH_8);
                    1: begin
                        fmt_buf.push_back(fdc_pkg::CH_0);
                        fmt_buf.push_back(fdc_pkg::CH_8);
                    end
                    2: begin
                        fmt_buf.push_back(fdc_pkg::CH_1);
                        fmt_buf.push_back(fdc_pkg::CH_6);
                    end
                    3: begin
                        fmt_buf.push_back(fdc_pkg::CH_3);
                        fmt_buf.push_back(fdc_pkg::CH_2);
                    end
                    default: begin
                        fmt_buf.push_back(
                            fdc_pkg::CHAR_W'(fdc_pkg::CH_0 + $urandom_range(0, 9)));
                        fmt_buf.push_back(
                            fdc_pkg::CHAR_W'(fdc_pkg::CH_0 + $urandom_range(0, 9)));
                    end
                endcase
                if ($urandom_range(0, 1) == 1) add_list(0);
                else add_noise(0, 3);
            end
            7: add_noise(1, 8);
            8: begin
                // A well-formed string with one character dropped or one inserted.
                add_list(0);
                idx = $urandom_range(0, fmt_buf.size() - 1);
                if (fmt_buf.size() > 1 && $urandom_range(0, 1) == 1) fmt_buf.delete(idx);
                else fmt_buf.insert(idx, JUNK_CHARS[$urandom_range(0, JUNK_CHARS.len() - 1)]);
            end
            9: begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1) == 1) begin
                        fmt_buf.push_back(fdc_pkg::CH_SPACE);
                    end else begin
                        fmt_buf.push_back(
                            fdc_pkg::CHAR_W'(fdc_pkg::CH_0 + $urandom_range(0, 9)));
                    end
                end
            end
            default: add_list(0);
        endcase
    endtask

    task automatic test_letters_and_groups();
        send_text("2(F,i),J");
        send_text("a,k, Z ,c");
        send_text("12345f");
        send_text("0I");
    endtask

    task automatic test_prefixes();
        send_text("B16");
        send_text("b8");
        send_text("B08F");
        send_text("b32((");
        send_text("B0");
        send_text("b");
    endtask

    task automatic test_errors_and_empty();
        send_text(" ");
        send_text("7");
        send_text("FF");
        send_text(")");
        send_text("F(");
        send_text("3,F");
        send_text("F1");
        fmt_buf.push_back(8'h00);
        send_fmt();
        fmt_buf.push_back("F");
        fmt_buf.push_back(8'h80);
        send_fmt();
        fmt_buf.push_back(8'hFF);
        send_fmt();
    endtask

    // A full store answers normally; one code more turns the answer into an error.
    task automatic test_store_limit();
        for (int extra = 0; extra < 2; extra++) begin
            for (int i = 0; i < DEPTH + extra; i++) begin
                if (i != 0) fmt_buf.push_back(fdc_pkg::CH_COMMA);
                fmt_buf.push_back(KIND_CHARS[i % 7]);
            end
            send_fmt();
        end
    endtask

    task automatic test_nesting();
        send_text("((F))");
        repeat (70) fmt_buf.push_back(fdc_pkg::CH_OPEN);
        repeat (70) fmt_buf.push_back(fdc_pkg::CH_CLOSE);
        send_fmt();
    endtask

    task automatic test_random_strings();
        int  first;
        bit  paused;
        first  = chars_sent;
        paused = 1'b0;
        while (chars_sent - first < RANDOM_CHARS) begin
            if (chars_sent - first >= RANDOM_CHARS - QUIET_CHARS) gap_pct = 0;
            else gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
            if (!paused && chars_sent - first >= RANDOM_CHARS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            build_random_fmt();
            send_fmt();
        end
    endtask

    initial begin
        clear_compiler();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_letters_and_groups();
        test_prefixes();
        test_errors_and_empty();
        test_store_limit();
        test_nesting();
        test_random_strings();
        wait_drained();
        $display("Compiled %0d format strings from %0d characters; %0d result codes checked.",
                 strings_sent, chars_sent, codes_checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
